@@ rtl/core/adjustable_traffic_light_controller_assert.svh @@
// Assertion macros for the traffic light controller.
// Used by files that check their own logic; expects clk_i and rst_ni in scope.
`ifndef ADJUSTABLE_TRAFFIC_LIGHT_CONTROLLER_ASSERT_SVH
`define ADJUSTABLE_TRAFFIC_LIGHT_CONTROLLER_ASSERT_SVH

// Check that cons holds in the cycle in which ante holds.
`define TLC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that cons holds in the cycle after the one in which ante holds.
`define TLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/tlc_pkg.sv @@
// Shared types, constants and helpers for the traffic light controller.
// No dependencies; used by tlc_seq and the top level.
package tlc_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL      = 2'd0,
    MODE_EDIT_RED    = 2'd1,
    MODE_EDIT_GREEN  = 2'd2,
    MODE_EDIT_YELLOW = 2'd3
  } tlc_mode_e;

  typedef enum logic [1:0] {
    PH_A_GREEN  = 2'd0,
    PH_A_YELLOW = 2'd1,
    PH_B_GREEN  = 2'd2,
    PH_B_YELLOW = 2'd3
  } tlc_phase_e;

  localparam int unsigned SecW   = 7;
  localparam int unsigned TickW  = 11;
  localparam int unsigned BlinkW = 8;
  localparam int unsigned LampW  = 3;

  localparam logic [LampW-1:0] LampOff    = 3'b000;
  localparam logic [LampW-1:0] LampRed    = 3'b001;
  localparam logic [LampW-1:0] LampYellow = 3'b010;
  localparam logic [LampW-1:0] LampGreen  = 3'b100;

  // durations are kept in 20-tick units
  localparam logic [SecW-1:0] SecMax        = 7'd99;
  localparam logic [SecW-1:0] RedInitSec    = 7'd13;
  localparam logic [SecW-1:0] YellowInitSec = 7'd3;
  localparam logic [SecW-1:0] GreenInitSec  = 7'd10;

  localparam logic [BlinkW-1:0] BlinkInit = 8'd10;

  typedef struct packed {
    logic [LampW-1:0] side_a;
    logic [LampW-1:0] side_b;
    tlc_mode_e        mode;
    logic [SecW-1:0]  red_sec;
    logic [SecW-1:0]  yellow_sec;
    logic [SecW-1:0]  green_sec;
  } tlc_result_t;

  // seconds * 20 = seconds * 16 + seconds * 4
  function automatic logic [TickW-1:0] sec_to_ticks(logic [SecW-1:0] sec);
    logic [TickW-1:0] ext;
    ext = {{(TickW-SecW){1'b0}}, sec};
    return (ext << 4) + (ext << 2);
  endfunction

  function automatic logic [SecW-1:0] sec_step(logic [SecW-1:0] sec);
    return (sec >= SecMax) ? SecMax : sec + 7'd1;
  endfunction

endpackage

@@ rtl/core/adjustable_traffic_light_controller.sv @@
// Top level of the adjustable two-way traffic light controller.
// Holds the blink register, the handshake and the result register; uses tlc_pkg and tlc_seq.
//
// Usage: each input transfer is one 50 ms tick carrying the mode, increase and
// commit press pulses. Every tick yields exactly one result transfer with the
// lamps of both sides, the current mode and the three edited durations in
// 20-tick units. The tick is applied to the controller state at its input
// transfer and the result is captured in an output register, so the result is
// offered in the cycle after the input transfer. One tick is taken every cycle
// while the output register is empty or is being drained in the same cycle.
// When the receiver stalls, the result holds and the input waits; nothing is
// dropped. The blink register is written through cfg_we_i/cfg_wdata_i and
// takes effect on the next tick. Reset empties the output register, sets the
// mode to normal with the first phase pending, loads the default durations
// (red 260, yellow 60, green 200 ticks) and sets the blink register to 10.
`include "adjustable_traffic_light_controller_assert.svh"

module adjustable_traffic_light_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tlc_pkg::BlinkW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_press_i,
  input  logic                        increase_press_i,
  input  logic                        commit_press_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tlc_pkg::LampW-1:0]   side_a_lamps_o,
  output logic [tlc_pkg::LampW-1:0]   side_b_lamps_o,
  output logic [1:0]                  current_mode_o,
  output logic [tlc_pkg::SecW-1:0]    edit_red_seconds_o,
  output logic [tlc_pkg::SecW-1:0]    edit_yellow_seconds_o,
  output logic [tlc_pkg::SecW-1:0]    edit_green_seconds_o
);

  logic [tlc_pkg::BlinkW-1:0] blink_half_q;
  logic                       out_valid_q, out_valid_d;
  tlc_pkg::tlc_result_t       res_q, res_d;
  logic                       in_xfer;
  logic                       edit_mode;
  logic                       secs_in_range;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_d = in_xfer || (out_valid_q && !out_ready_i);

  tlc_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (in_xfer),
    .mode_press_i     (mode_press_i),
    .increase_press_i (increase_press_i),
    .commit_press_i   (commit_press_i),
    .blink_half_i     (blink_half_q),
    .result_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_half_q <= tlc_pkg::BlinkInit;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        blink_half_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign side_a_lamps_o        = res_q.side_a;
  assign side_b_lamps_o        = res_q.side_b;
  assign current_mode_o        = res_q.mode;
  assign edit_red_seconds_o    = res_q.red_sec;
  assign edit_yellow_seconds_o = res_q.yellow_sec;
  assign edit_green_seconds_o  = res_q.green_sec;

  assign edit_mode     = (res_q.mode != tlc_pkg::MODE_NORMAL);
  assign secs_in_range = (edit_red_seconds_o <= tlc_pkg::SecMax)
                      && (edit_yellow_seconds_o <= tlc_pkg::SecMax)
                      && (edit_green_seconds_o <= tlc_pkg::SecMax);

  `TLC_ASSERT_NEXT(a_xfer_gives_result, in_valid_i && in_ready_o, out_valid_o)
  `TLC_ASSERT_SAME(a_no_overwrite, out_valid_o && !out_ready_i, !in_ready_o)
  `TLC_ASSERT_SAME(a_edit_sides_match, out_valid_o && edit_mode, side_a_lamps_o == side_b_lamps_o)
  `TLC_ASSERT_SAME(a_seconds_range, out_valid_o, secs_in_range)

endmodule

@@ rtl/core/tlc_seq.sv @@
// Controller state: mode, phase sequencer, durations and blink timer.
// Computes the result of one tick from the registered state; uses tlc_pkg.
module tlc_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        mode_press_i,
  input  logic                        increase_press_i,
  input  logic                        commit_press_i,
  input  logic [tlc_pkg::BlinkW-1:0]  blink_half_i,
  output tlc_pkg::tlc_result_t        result_o
);

  tlc_pkg::tlc_mode_e            mode_q, mode_d;
  tlc_pkg::tlc_phase_e           phase_q, phase_d;
  logic [tlc_pkg::TickW-1:0]     cd_q, cd_d;
  logic [tlc_pkg::SecW-1:0]      com_red_q, com_red_d;
  logic [tlc_pkg::SecW-1:0]      com_yel_q, com_yel_d;
  logic [tlc_pkg::SecW-1:0]      com_grn_q, com_grn_d;
  logic [tlc_pkg::SecW-1:0]      ed_red_q, ed_red_d;
  logic [tlc_pkg::SecW-1:0]      ed_yel_q, ed_yel_d;
  logic [tlc_pkg::SecW-1:0]      ed_grn_q, ed_grn_d;
  logic [tlc_pkg::BlinkW-1:0]    blink_cnt_q, blink_cnt_d;
  logic                          blink_on_q, blink_on_d;
  logic [2*tlc_pkg::LampW-1:0]   lamps_q, lamps_d;

  logic [1:0]                    mode_inc;
  logic [1:0]                    phase_inc;
  logic [tlc_pkg::TickW-1:0]     cd_cur;
  logic [tlc_pkg::TickW-1:0]     cd_load;
  logic [tlc_pkg::BlinkW-1:0]    half_eff;
  logic [tlc_pkg::BlinkW:0]      blink_inc;

  assign mode_inc  = mode_q + 2'd1;
  assign phase_inc = phase_q + 2'd1;
  assign half_eff  = (blink_half_i == '0) ? 8'd1 : blink_half_i;
  assign blink_inc = {1'b0, blink_cnt_q} + 9'd1;

  always_comb begin
    mode_d      = mode_q;
    phase_d     = phase_q;
    cd_d        = cd_q;
    com_red_d   = com_red_q;
    com_yel_d   = com_yel_q;
    com_grn_d   = com_grn_q;
    ed_red_d    = ed_red_q;
    ed_yel_d    = ed_yel_q;
    ed_grn_d    = ed_grn_q;
    blink_cnt_d = blink_cnt_q;
    blink_on_d  = blink_on_q;
    lamps_d     = lamps_q;
    cd_load     = cd_q;

    if (mode_press_i) begin
      mode_d = tlc_pkg::tlc_mode_e'(mode_inc);
    end
    cd_cur = (mode_press_i && (mode_d == tlc_pkg::MODE_NORMAL)) ? '0 : cd_q;

    if (mode_d == tlc_pkg::MODE_NORMAL) begin
      if (cd_cur == '0) begin
        case (phase_q)
          tlc_pkg::PH_A_GREEN: begin
            lamps_d = {tlc_pkg::LampRed, tlc_pkg::LampGreen};
            cd_load = tlc_pkg::sec_to_ticks(com_grn_q);
          end
          tlc_pkg::PH_A_YELLOW: begin
            lamps_d = {tlc_pkg::LampRed, tlc_pkg::LampYellow};
            cd_load = tlc_pkg::sec_to_ticks(com_yel_q);
          end
          tlc_pkg::PH_B_GREEN: begin
            lamps_d = {tlc_pkg::LampGreen, tlc_pkg::LampRed};
            cd_load = tlc_pkg::sec_to_ticks(com_grn_q);
          end
          default: begin
            lamps_d = {tlc_pkg::LampYellow, tlc_pkg::LampRed};
            cd_load = tlc_pkg::sec_to_ticks(com_yel_q);
          end
        endcase
        phase_d = tlc_pkg::tlc_phase_e'(phase_inc);
      end else begin
        cd_load = cd_cur;
      end
      cd_d = cd_load - 11'd1;
    end else begin
      if (increase_press_i) begin
        case (mode_d)
          tlc_pkg::MODE_EDIT_RED:   ed_red_d = tlc_pkg::sec_step(ed_red_q);
          tlc_pkg::MODE_EDIT_GREEN: ed_grn_d = tlc_pkg::sec_step(ed_grn_q);
          default:                  ed_yel_d = tlc_pkg::sec_step(ed_yel_q);
        endcase
      end else if (commit_press_i) begin
        case (mode_d)
          tlc_pkg::MODE_EDIT_RED:   com_red_d = ed_red_q;
          tlc_pkg::MODE_EDIT_GREEN: com_grn_d = ed_grn_q;
          default:                  com_yel_d = ed_yel_q;
        endcase
      end else if (mode_press_i) begin
        ed_red_d = com_red_q;
        ed_yel_d = com_yel_q;
        ed_grn_d = com_grn_q;
      end
      if (blink_cnt_q == '0) begin
        blink_on_d = ~blink_on_q;
      end
      blink_cnt_d = (blink_inc >= {1'b0, half_eff}) ? '0 : blink_inc[tlc_pkg::BlinkW-1:0];
    end
  end

  always_comb begin
    result_o.mode       = mode_d;
    result_o.red_sec    = ed_red_d;
    result_o.yellow_sec = ed_yel_d;
    result_o.green_sec  = ed_grn_d;
    result_o.side_a     = tlc_pkg::LampOff;
    case (mode_d)
      tlc_pkg::MODE_NORMAL:     result_o.side_a = lamps_d[tlc_pkg::LampW-1:0];
      tlc_pkg::MODE_EDIT_RED:   result_o.side_a = blink_on_d ? tlc_pkg::LampRed
                                                             : tlc_pkg::LampOff;
      tlc_pkg::MODE_EDIT_GREEN: result_o.side_a = blink_on_d ? tlc_pkg::LampGreen
                                                             : tlc_pkg::LampOff;
      default:                  result_o.side_a = blink_on_d ? tlc_pkg::LampYellow
                                                             : tlc_pkg::LampOff;
    endcase
    result_o.side_b = (mode_d == tlc_pkg::MODE_NORMAL)
                    ? lamps_d[2*tlc_pkg::LampW-1:tlc_pkg::LampW] : result_o.side_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= tlc_pkg::MODE_NORMAL;
      phase_q     <= tlc_pkg::PH_A_GREEN;
      cd_q        <= '0;
      com_red_q   <= tlc_pkg::RedInitSec;
      com_yel_q   <= tlc_pkg::YellowInitSec;
      com_grn_q   <= tlc_pkg::GreenInitSec;
      ed_red_q    <= tlc_pkg::RedInitSec;
      ed_yel_q    <= tlc_pkg::YellowInitSec;
      ed_grn_q    <= tlc_pkg::GreenInitSec;
      blink_cnt_q <= '0;
      blink_on_q  <= 1'b0;
      lamps_q     <= '0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      phase_q     <= phase_d;
      cd_q        <= cd_d;
      com_red_q   <= com_red_d;
      com_yel_q   <= com_yel_d;
      com_grn_q   <= com_grn_d;
      ed_red_q    <= ed_red_d;
      ed_yel_q    <= ed_yel_d;
      ed_grn_q    <= ed_grn_d;
      blink_cnt_q <= blink_cnt_d;
      blink_on_q  <= blink_on_d;
      lamps_q     <= lamps_d;
    end
  end

endmodule

@@ bench/adjustable_traffic_light_controller_checker.sv @@
// Checker for the traffic light controller: follows tick and result transfers,
// predicts every result from its own copy of the controller state and compares it.
// Depends on tlc_pkg.
module adjustable_traffic_light_controller_checker
  import tlc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BlinkW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              mode_press_i,
  input  logic              increase_press_i,
  input  logic              commit_press_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [LampW-1:0]  side_a_lamps_i,
  input  logic [LampW-1:0]  side_b_lamps_i,
  input  logic [1:0]        current_mode_i,
  input  logic [SecW-1:0]   edit_red_seconds_i,
  input  logic [SecW-1:0]   edit_yellow_seconds_i,
  input  logic [SecW-1:0]   edit_green_seconds_i,
  output int                mismatches_o,
  output int                outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TickW-1:0] StepTicks       = 11'd20;
  localparam logic [TickW-1:0] MaxTicks        = 11'd1980;
  localparam logic [TickW-1:0] RedInitTicks    = 11'd260;
  localparam logic [TickW-1:0] YellowInitTicks = 11'd60;
  localparam logic [TickW-1:0] GreenInitTicks  = 11'd200;

  tlc_mode_e         mode_q;
  tlc_phase_e        next_phase_q;
  logic [TickW-1:0]  countdown_q;
  logic [TickW-1:0]  committed_q [1:3];
  logic [TickW-1:0]  edited_q [1:3];
  logic [BlinkW-1:0] blink_half_q;
  logic [BlinkW-1:0] blink_count_q;
  logic              blink_on_q;
  logic [LampW-1:0]  held_a_q;
  logic [LampW-1:0]  held_b_q;
  tlc_result_t       lamp_results_q[$];
  int                mismatches;

  function automatic tlc_result_t predict_tick(input logic mode_p, inc_p, commit_p);
    tlc_result_t      r;
    logic [1:0]       nxt_mode;
    logic [1:0]       nxt_phase;
    int               sum;
    int               half;
    logic [LampW-1:0] lamp;
    if (mode_p) begin
      nxt_mode = mode_q + 2'd1;
      mode_q = tlc_mode_e'(nxt_mode);
      if (mode_q == MODE_NORMAL) countdown_q = '0;
    end
    if (mode_q == MODE_NORMAL) begin
      if (countdown_q == '0) begin
        case (next_phase_q)
          PH_A_GREEN: begin
            held_a_q = LampGreen;
            held_b_q = LampRed;
            countdown_q = committed_q[MODE_EDIT_GREEN];
          end
          PH_A_YELLOW: begin
            held_a_q = LampYellow;
            held_b_q = LampRed;
            countdown_q = committed_q[MODE_EDIT_YELLOW];
          end
          PH_B_GREEN: begin
            held_a_q = LampRed;
            held_b_q = LampGreen;
            countdown_q = committed_q[MODE_EDIT_GREEN];
          end
          PH_B_YELLOW: begin
            held_a_q = LampRed;
            held_b_q = LampYellow;
            countdown_q = committed_q[MODE_EDIT_YELLOW];
          end
        endcase
        nxt_phase = next_phase_q + 2'd1;
        next_phase_q = tlc_phase_e'(nxt_phase);
      end
      countdown_q = countdown_q - 1'b1;
      r.side_a = held_a_q;
      r.side_b = held_b_q;
    end else begin
      if (inc_p) begin
        sum = edited_q[mode_q] + StepTicks;
        edited_q[mode_q] = (sum > MaxTicks) ? MaxTicks : TickW'(sum);
      end else if (commit_p) begin
        committed_q[mode_q] = edited_q[mode_q];
      end else if (mode_p) begin
        edited_q = committed_q;
      end
      half = (blink_half_q == '0) ? 1 : int'(blink_half_q);
      if (blink_count_q == '0) blink_on_q = ~blink_on_q;
      blink_count_q = (blink_count_q + 1 >= half) ? '0 : blink_count_q + 1'b1;
      case (mode_q)
        MODE_EDIT_RED:   lamp = LampRed;
        MODE_EDIT_GREEN: lamp = LampGreen;
        default:         lamp = LampYellow;
      endcase
      r.side_a = blink_on_q ? lamp : LampOff;
      r.side_b = r.side_a;
    end
    r.mode = mode_q;
    r.red_sec = SecW'(edited_q[MODE_EDIT_RED] / StepTicks);
    r.yellow_sec = SecW'(edited_q[MODE_EDIT_YELLOW] / StepTicks);
    r.green_sec = SecW'(edited_q[MODE_EDIT_GREEN] / StepTicks);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tlc_result_t want;
    if (!rst_ni) begin
      mode_q = MODE_NORMAL;
      next_phase_q = PH_A_GREEN;
      countdown_q = '0;
      committed_q[MODE_EDIT_RED] = RedInitTicks;
      committed_q[MODE_EDIT_GREEN] = GreenInitTicks;
      committed_q[MODE_EDIT_YELLOW] = YellowInitTicks;
      edited_q = committed_q;
      blink_half_q = BlinkInit;
      blink_count_q = '0;
      blink_on_q = 1'b0;
      held_a_q = LampOff;
      held_b_q = LampOff;
      lamp_results_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (lamp_results_q.size() == 0) begin
          $error("result transfer with no tick outstanding");
          mismatches++;
        end else begin
          want = lamp_results_q.pop_front();
          check_field("side_a_lamps", want.side_a, side_a_lamps_i);
          check_field("side_b_lamps", want.side_b, side_b_lamps_i);
          check_field("current_mode", want.mode, current_mode_i);
          check_field("edit_red_seconds", want.red_sec, edit_red_seconds_i);
          check_field("edit_yellow_seconds", want.yellow_sec, edit_yellow_seconds_i);
          check_field("edit_green_seconds", want.green_sec, edit_green_seconds_i);
        end
      end
      if (cfg_we_i) blink_half_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        lamp_results_q.push_back(predict_tick(mode_press_i, increase_press_i, commit_press_i));
      end
    end
    mismatches_o <= mismatches;
    outstanding_o <= lamp_results_q.size();
  end

endmodule

@@ bench/adjustable_traffic_light_controller_test.sv @@
// Top of the traffic light controller bench: clock, reset, tick stimulus and receiver.
// Instantiates the controller and its checker; depends on tlc_pkg.
module adjustable_traffic_light_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tlc_pkg::*;

  localparam int ClkPeriod     = 2;
  localparam int ResetCycles   = 10;
  localparam int WatchdogLimit = 2000;
  localparam int LongHold      = 50;
  localparam int StageTicks    = 110;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [BlinkW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              mode_press_i = 1'b0;
  logic              increase_press_i = 1'b0;
  logic              commit_press_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [LampW-1:0]  side_a_lamps_o;
  logic [LampW-1:0]  side_b_lamps_o;
  logic [1:0]        current_mode_o;
  logic [SecW-1:0]   edit_red_seconds_o;
  logic [SecW-1:0]   edit_yellow_seconds_o;
  logic [SecW-1:0]   edit_green_seconds_o;

  int        mismatches;
  int        outstanding;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      hold_toggle = 1'b0;
  logic      hold_seen = 1'b0;
  int        hold_left = 0;
  int        quiet_cycles = 0;
  int        ticks_sent = 0;
  int        blink_writes = 0;
  tlc_mode_e plan_mode = MODE_NORMAL;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  adjustable_traffic_light_controller dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .mode_press_i          (mode_press_i),
    .increase_press_i      (increase_press_i),
    .commit_press_i        (commit_press_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .side_a_lamps_o        (side_a_lamps_o),
    .side_b_lamps_o        (side_b_lamps_o),
    .current_mode_o        (current_mode_o),
    .edit_red_seconds_o    (edit_red_seconds_o),
    .edit_yellow_seconds_o (edit_yellow_seconds_o),
    .edit_green_seconds_o  (edit_green_seconds_o)
  );

  adjustable_traffic_light_controller_checker lamp_check (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_ready_i            (in_ready_o),
    .mode_press_i          (mode_press_i),
    .increase_press_i      (increase_press_i),
    .commit_press_i        (commit_press_i),
    .out_valid_i           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .side_a_lamps_i        (side_a_lamps_o),
    .side_b_lamps_i        (side_b_lamps_o),
    .current_mode_i        (current_mode_o),
    .edit_red_seconds_i    (edit_red_seconds_o),
    .edit_yellow_seconds_i (edit_yellow_seconds_o),
    .edit_green_seconds_i  (edit_green_seconds_o),
    .mismatches_o          (mismatches),
    .outstanding_o         (outstanding)
  );

  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= LongHold;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("adjustable_traffic_light_controller regression: fail");
      $finish;
    end
  end

  function automatic logic coin(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic send_tick(input logic mode_p, inc_p, commit_p);
    logic [1:0] nxt;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_press_i <= mode_p;
    increase_press_i <= inc_p;
    commit_press_i <= commit_p;
    do @(posedge clk_i); while (!in_ready_o);
    ticks_sent++;
    if (mode_p) begin
      nxt = plan_mode + 2'd1;
      plan_mode = tlc_mode_e'(nxt);
    end
  endtask

  task automatic go_to_mode(input tlc_mode_e target);
    while (plan_mode != target) send_tick(1'b1, coin(10), coin(10));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_blink(input logic [BlinkW-1:0] half);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= half;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    blink_writes++;
  endtask

  task automatic run_sessions(input int ticks_target);
    int        n;
    int        inc_pct;
    tlc_mode_e target;
    while (ticks_sent < ticks_target) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          go_to_mode(MODE_NORMAL);
          repeat ($urandom_range(10, 120)) send_tick(1'b0, coin(50), coin(50));
        end
        4, 5, 6, 7: begin
          target = tlc_mode_e'(2'($urandom_range(1, 3)));
          go_to_mode(target);
          inc_pct = (target == MODE_EDIT_RED) ? 85 : 30;
          n = $urandom_range(5, (target == MODE_EDIT_RED) ? 120 : 40);
          repeat (n) send_tick(coin(3), coin(inc_pct), coin(10));
        end
        default: begin
          repeat ($urandom_range(3, 15)) send_tick(coin(50), coin(50), coin(50));
        end
      endcase
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_blink(8'd1);

    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);

    drain_results();
    write_blink('0);
    go_to_mode(MODE_EDIT_GREEN);
    repeat (5) send_tick(1'b0, coin(50), 1'b0);

    for (int stage = 0; stage < 3; stage++) begin
      drain_results();
      send_idle_pct = (stage == 0) ? 33 : (stage == 1) ? 53 : 0;
      recv_idle_pct <= (stage == 0) ? 53 : (stage == 1) ? 33 : 0;
      if (stage == 0) begin
        write_blink(8'd255);
        go_to_mode(MODE_EDIT_RED);
        repeat (40) send_tick(1'b0, coin(50), coin(20));
        drain_results();
        write_blink(8'd3);
      end else if (stage == 1) begin
        write_blink(8'($urandom_range(4, 12)));
      end else begin
        write_blink(8'($urandom_range(2, 255)));
        hold_toggle <= ~hold_toggle;
        repeat (20) send_tick(coin(10), coin(50), coin(50));
      end
      run_sessions(ticks_sent + StageTicks);
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d ticks through all four modes under %0d blink settings,",
             ticks_sent, blink_writes);
    $display("0, 1 and 255 among them, with sender and receiver stalls and a long hold.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("adjustable_traffic_light_controller regression: pass");
    end else begin
      $display("adjustable_traffic_light_controller regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/tlc_pkg.sv
rtl/core/tlc_seq.sv
rtl/core/adjustable_traffic_light_controller.sv
bench/adjustable_traffic_light_controller_checker.sv
bench/adjustable_traffic_light_controller_test.sv
